// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== src/ppm_pkg.sv =====
// ---------------------------------------------------------------------------
// ppm_pkg
// shared constants, result type and helpers for the P6 header parser
// ---------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

   // width of the parsed size values and the number accumulator
   localparam int DIM_BITS  = 16;
   localparam int IMG_W     = 16;
   localparam int ACC_X10_W = DIM_BITS + 4;

   // parser states
   localparam logic [3:0] ST_P    = 4'd0;
   localparam logic [3:0] ST_SIX  = 4'd1;
   localparam logic [3:0] ST_SEP  = 4'd2;
   localparam logic [3:0] ST_W0   = 4'd3;
   localparam logic [3:0] ST_W1   = 4'd4;
   localparam logic [3:0] ST_H0   = 4'd5;
   localparam logic [3:0] ST_H1   = 4'd6;
   localparam logic [3:0] ST_M0   = 4'd7;
   localparam logic [3:0] ST_M1   = 4'd8;
   localparam logic [3:0] ST_PIX  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;
   localparam logic [3:0] ST_ERR  = 4'd11;

   // reported phase
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXELS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_ERROR  = 2'd3;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_NO_P      = 4'd1;
   localparam logic [3:0] ERR_NO_6      = 4'd2;
   localparam logic [3:0] ERR_MAGIC_LEN = 4'd3;
   localparam logic [3:0] ERR_EOF_CMT   = 4'd4;
   localparam logic [3:0] ERR_NO_DIGIT  = 4'd5;
   localparam logic [3:0] ERR_NON_DIGIT = 4'd6;
   localparam logic [3:0] ERR_MAXVAL    = 4'd7;
   localparam logic [3:0] ERR_ZERO_SIZE = 4'd8;
   localparam logic [3:0] ERR_TRUNC     = 4'd9;
   localparam logic [3:0] ERR_OVERFLOW  = 4'd10;

   // characters
   localparam logic [7:0] CH_P     = 8'd80;
   localparam logic [7:0] CH_SIX   = 8'd54;
   localparam logic [7:0] CH_HASH  = 8'd35;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [DIM_BITS-1:0] MAXVAL_REQ = DIM_BITS'(255);

   localparam logic [1:0] CHAN_BLUE = 2'd2;

   typedef struct packed {
      logic [1:0]       phase;
      logic [3:0]       error_code;
      logic [IMG_W-1:0] image_width;
      logic [IMG_W-1:0] image_height;
      logic             pixel_valid;
      logic [7:0]       pixel_value;
      logic [1:0]       color_channel;
      logic             last_pixel;
   } rsp_type;

   function automatic logic is_ws(input logic [7:0] b);
      return b inside {[CH_TAB:CH_CR], CH_SPACE};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[CH_ZERO:CH_NINE]};
   endfunction

endpackage

`default_nettype wire

// ===== src/ppm_p6_header_parser.sv =====
// ---------------------------------------------------------------------------
// ppm_p6_header_parser
// P6 header parser and pixel tagger, one file byte per transfer
// ---------------------------------------------------------------------------
// Each input transfer carries one file byte (or an end-of-file mark) and
// yields exactly one result transfer. The byte is parsed by single-cycle
// logic against the parser state and the result is written into a two-entry
// output buffer, so a byte can be taken every cycle; req_ready drops only
// when both buffer entries hold results the consumer has not yet taken.
// Errors are sticky and only reset clears them.
`default_nettype none
`include "assert_macros.svh"

module ppm_p6_header_parser
   import ppm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_end_of_file,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic [1:0]       rsp_phase,
   output      logic [3:0]       rsp_error_code,
   output      logic [IMG_W-1:0] rsp_image_width,
   output      logic [IMG_W-1:0] rsp_image_height,
   output      logic             rsp_pixel_valid,
   output      logic [7:0]       rsp_pixel_value,
   output      logic [1:0]       rsp_color_channel,
   output      logic             rsp_last_pixel
);

   // parser state
   logic [3:0]          state_ff,   state_in;
   logic [3:0]          ret_ff,     ret_in;
   logic                cmt_ff,     cmt_in;
   logic [DIM_BITS-1:0] acc_ff,     acc_in;
   logic [DIM_BITS-1:0] width_ff,   width_in;
   logic [DIM_BITS-1:0] height_ff,  height_in;
   logic [1:0]          chan_ff,    chan_in;
   logic [DIM_BITS-1:0] col_ff,     col_in;
   logic [DIM_BITS-1:0] row_ff,     row_in;
   logic [3:0]          err_ff,     err_in;

   // output buffer
   rsp_type             head_ff,    head_in;
   rsp_type             skid_ff,    skid_in;
   logic [1:0]          count_ff,   count_in;

   rsp_type             res;
   logic                push;
   logic                pop;

   logic                eof;
   logic [7:0]          b;
   logic [ACC_X10_W-1:0] acc_ext;
   logic [ACC_X10_W-1:0] acc_x10;
   logic                acc_ovf;
   logic [DIM_BITS:0]   col_next;
   logic [DIM_BITS:0]   row_next;

   assign eof = req_end_of_file;
   assign b   = req_data_byte;

   // acc * 10 + digit, overflow when any bit above the dimension width is set
   assign acc_ext  = ACC_X10_W'(acc_ff);
   assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + ACC_X10_W'(b[3:0]);
   assign acc_ovf  = |acc_x10[ACC_X10_W-1:DIM_BITS];

   assign col_next = {1'b0, col_ff} + (DIM_BITS+1)'(1);
   assign row_next = {1'b0, row_ff} + (DIM_BITS+1)'(1);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmt_in    = cmt_ff;
      acc_in    = acc_ff;
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      err_in    = err_ff;

      res               = '0;

      if (state_ff == ST_ERR || state_ff == ST_DONE) begin
         // input ignored
      end else if (cmt_ff) begin
         if (eof) begin
            err_in   = ERR_EOF_CMT;
            state_in = ST_ERR;
            cmt_in   = 1'b0;
         end else if (b == CH_LF || b == CH_CR) begin
            cmt_in   = 1'b0;
            state_in = ret_ff;
         end
      end else if (state_ff == ST_PIX) begin
         if (eof) begin
            err_in   = ERR_TRUNC;
            state_in = ST_ERR;
         end else begin
            res.pixel_valid   = 1'b1;
            res.pixel_value   = b;
            res.color_channel = chan_ff;
            if (chan_ff >= CHAN_BLUE) begin
               chan_in = '0;
               if (col_next >= {1'b0, width_ff}) begin
                  col_in = '0;
                  if (row_next >= {1'b0, height_ff}) begin
                     res.last_pixel = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     row_in = row_next[DIM_BITS-1:0];
                  end
               end else begin
                  col_in = col_next[DIM_BITS-1:0];
               end
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
      end else if (!eof && b == CH_HASH) begin
         cmt_in = 1'b1;
         ret_in = state_ff;
      end else begin
         case (state_ff)
            ST_P: begin
               if (!eof && b == CH_P) state_in = ST_SIX;
               else begin
                  err_in   = ERR_NO_P;
                  state_in = ST_ERR;
               end
            end
            ST_SIX: begin
               if (!eof && b == CH_SIX) state_in = ST_SEP;
               else begin
                  err_in   = ERR_NO_6;
                  state_in = ST_ERR;
               end
            end
            ST_SEP: begin
               if (!eof && is_ws(b)) state_in = ST_W0;
               else begin
                  err_in   = ERR_MAGIC_LEN;
                  state_in = ST_ERR;
               end
            end
            ST_W0, ST_H0, ST_M0: begin
               if (!eof && is_ws(b)) begin
                  // leading whitespace skipped
               end else if (!eof && is_digit(b)) begin
                  // a single digit always fits
                  acc_in   = DIM_BITS'(b[3:0]);
                  state_in = state_ff + 4'd1;
               end else begin
                  err_in   = ERR_NO_DIGIT;
                  state_in = ST_ERR;
               end
            end
            ST_W1, ST_H1, ST_M1: begin
               if (!eof && is_ws(b)) begin
                  acc_in = '0;
                  if (state_ff == ST_W1) begin
                     width_in = acc_ff;
                     state_in = ST_H0;
                  end else if (state_ff == ST_H1) begin
                     height_in = acc_ff;
                     state_in  = ST_M0;
                  end else if (acc_ff != MAXVAL_REQ) begin
                     err_in   = ERR_MAXVAL;
                     state_in = ST_ERR;
                  end else if (width_ff == '0 || height_ff == '0) begin
                     err_in   = ERR_ZERO_SIZE;
                     state_in = ST_ERR;
                  end else begin
                     state_in = ST_PIX;
                     chan_in  = '0;
                     col_in   = '0;
                     row_in   = '0;
                  end
               end else if (!eof && is_digit(b)) begin
                  if (acc_ovf) begin
                     acc_in   = {DIM_BITS{1'b1}};
                     err_in   = ERR_OVERFLOW;
                     state_in = ST_ERR;
                  end else begin
                     acc_in = acc_x10[DIM_BITS-1:0];
                  end
               end else begin
                  err_in   = ERR_NON_DIGIT;
                  state_in = ST_ERR;
               end
            end
            default: begin
               state_in = ST_ERR;
            end
         endcase
      end

      case (state_in)
         ST_ERR:  res.phase = PH_ERROR;
         ST_DONE: res.phase = PH_DONE;
         ST_PIX:  res.phase = PH_PIXELS;
         default: res.phase = PH_HEADER;
      endcase
      res.error_code   = err_in;
      res.image_width  = IMG_W'(width_in);
      res.image_height = IMG_W'(height_in);
   end

   // two-entry output buffer: head drives the ports, skid catches a stalled result
   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = res;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = res;
            end else if (push) begin
               skid_in  = res;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_P;
         ret_ff    <= ST_P;
         cmt_ff    <= 1'b0;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         chan_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         err_ff    <= ERR_NONE;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            state_ff  <= state_in;
            ret_ff    <= ret_in;
            cmt_ff    <= cmt_in;
            acc_ff    <= acc_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            chan_ff   <= chan_in;
            col_ff    <= col_in;
            row_ff    <= row_in;
            err_ff    <= err_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_phase         = head_ff.phase;
   assign rsp_error_code    = head_ff.error_code;
   assign rsp_image_width   = head_ff.image_width;
   assign rsp_image_height  = head_ff.image_height;
   assign rsp_pixel_valid   = head_ff.pixel_valid;
   assign rsp_pixel_value   = head_ff.pixel_value;
   assign rsp_color_channel = head_ff.color_channel;
   assign rsp_last_pixel    = head_ff.last_pixel;

   `ASSERT_CLK(a_err_sticks, clock, reset, state_ff == ST_ERR |=> state_ff == ST_ERR, "error state left without reset")
   `ASSERT_CLK(a_err_code_match, clock, reset, (err_ff != ERR_NONE) == (state_ff == ST_ERR), "error code and parser state disagree")
   `ASSERT_CLK(a_pix_phase, clock, reset, (rsp_valid && rsp_pixel_valid) |-> (rsp_phase == PH_PIXELS || rsp_phase == PH_DONE), "pixel result outside pixel phase")
   `ASSERT_CLK(a_last_done, clock, reset, (rsp_valid && rsp_last_pixel) |-> (rsp_phase == PH_DONE && rsp_color_channel == CHAN_BLUE), "last pixel without completion")
   `ASSERT_CLK(a_ready_full, clock, reset, !req_ready |-> (rsp_valid && count_ff == 2'd2), "input stalled while buffer has room")

endmodule

`default_nettype wire

// ===== bench/tb_ppm_p6_header_parser.sv =====
// ---------------------------------------------------------------------------
// tb_ppm_p6_header_parser
// byte-stream testbench for the P6 header parser and pixel tagger
// ---------------------------------------------------------------------------
// Feeds one PPM file per run through the parser, one byte per transfer, and
// predicts every result from a local copy of the parser state. Reset is only
// applied once, so each seed picks one fate for the file: a complete image,
// a file cut short in the pixel phase, or one header fault. Header text is
// built with random whitespace, comments, leading zeros and comments inside
// numbers. Both sides idle at random; the receiver also holds off for a long
// stretch so that the output buffer fills and the input stalls.

module tb_ppm_p6_header_parser;
   import ppm_pkg::*;

   localparam int unsigned DIM_MAX     = (1 << DIM_BITS) - 1;
   localparam int          HOLD_CYCLES = 60;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_data_byte = '0;
   logic             req_end_of_file = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_phase;
   logic [3:0]       rsp_error_code;
   logic [IMG_W-1:0] rsp_image_width;
   logic [IMG_W-1:0] rsp_image_height;
   logic             rsp_pixel_valid;
   logic [7:0]       rsp_pixel_value;
   logic [1:0]       rsp_color_channel;
   logic             rsp_last_pixel;

   // parser state as the bench sees it
   logic [3:0]  hdr_state   = ST_P;
   logic [3:0]  note_resume = ST_P;
   logic        note_active = 1'b0;
   int unsigned num_acc     = 0;
   int unsigned img_w       = 0;
   int unsigned img_h       = 0;
   logic [1:0]  chan_idx    = '0;
   int unsigned col_idx     = 0;
   int unsigned row_idx     = 0;
   logic [3:0]  fault_code  = ERR_NONE;

   rsp_type predicted_rsp[$];
   int      mismatch_count  = 0;
   bit      idle_on         = 1'b1;
   int      holds_requested = 0;

   ppm_p6_header_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase         (rsp_phase),
      .rsp_error_code    (rsp_error_code),
      .rsp_image_width   (rsp_image_width),
      .rsp_image_height  (rsp_image_height),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_color_channel (rsp_color_channel),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   always #1 clock = ~clock;

   function automatic bit blank_byte(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic bit digit_byte(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic logic [7:0] blank_pick();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
   endfunction

   function automatic void set_fault(input logic [3:0] code);
      fault_code  = code;
      hdr_state   = ST_ERR;
      note_active = 1'b0;
   endfunction

   // advances the local parser by one byte and returns the result it owes
   function automatic rsp_type parse_byte(input logic [7:0] b, input logic e);
      rsp_type     r;
      logic [3:0]  s;
      int unsigned grown;
      r = '0;
      s = hdr_state;
      if (s == ST_ERR || s == ST_DONE) begin
         // everything ignored until reset
      end else if (note_active) begin
         if (e) set_fault(ERR_EOF_CMT);
         else if (b == CH_LF || b == CH_CR) begin
            note_active = 1'b0;
            hdr_state   = note_resume;
         end
      end else if (s == ST_PIX) begin
         if (e) set_fault(ERR_TRUNC);
         else begin
            r.pixel_valid   = 1'b1;
            r.pixel_value   = b;
            r.color_channel = chan_idx;
            if (chan_idx == CHAN_BLUE) begin
               chan_idx = '0;
               if (col_idx + 1 >= img_w) begin
                  col_idx = 0;
                  if (row_idx + 1 >= img_h) begin
                     r.last_pixel = 1'b1;
                     hdr_state    = ST_DONE;
                  end else row_idx++;
               end else col_idx++;
            end else chan_idx++;
         end
      end else if (!e && b == CH_HASH) begin
         note_active = 1'b1;
         note_resume = s;
      end else if (s == ST_P) begin
         if (!e && b == CH_P) hdr_state = ST_SIX; else set_fault(ERR_NO_P);
      end else if (s == ST_SIX) begin
         if (!e && b == CH_SIX) hdr_state = ST_SEP; else set_fault(ERR_NO_6);
      end else if (s == ST_SEP) begin
         if (!e && blank_byte(b)) hdr_state = ST_W0; else set_fault(ERR_MAGIC_LEN);
      end else if (s == ST_W0 || s == ST_H0 || s == ST_M0) begin
         if (e) set_fault(ERR_NO_DIGIT);
         else if (blank_byte(b)) begin
            // leading whitespace skipped
         end else if (digit_byte(b)) begin
            num_acc   = b - CH_ZERO;
            hdr_state = s + 4'd1;
         end else set_fault(ERR_NO_DIGIT);
      end else begin
         if (e) set_fault(ERR_NON_DIGIT);
         else if (blank_byte(b)) begin
            if (s == ST_W1) begin
               img_w     = num_acc;
               hdr_state = ST_H0;
            end else if (s == ST_H1) begin
               img_h     = num_acc;
               hdr_state = ST_M0;
            end else if (num_acc != MAXVAL_REQ) set_fault(ERR_MAXVAL);
            else if (img_w == 0 || img_h == 0) set_fault(ERR_ZERO_SIZE);
            else begin
               hdr_state = ST_PIX;
               chan_idx  = '0;
               col_idx   = 0;
               row_idx   = 0;
            end
            num_acc = 0;
         end else if (digit_byte(b)) begin
            grown = num_acc * 10 + (b - CH_ZERO);
            if (grown > DIM_MAX) begin
               num_acc = DIM_MAX;
               set_fault(ERR_OVERFLOW);
            end else num_acc = grown;
         end else set_fault(ERR_NON_DIGIT);
      end

      if (hdr_state == ST_ERR) r.phase = PH_ERROR;
      else if (hdr_state == ST_DONE) r.phase = PH_DONE;
      else if (hdr_state == ST_PIX) r.phase = PH_PIXELS;
      else r.phase = PH_HEADER;
      r.error_code   = fault_code;
      r.image_width  = img_w[IMG_W-1:0];
      r.image_height = img_h[IMG_W-1:0];
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic [7:0] b, input logic e);
      while (idle_on && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_file <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_rsp.push_back(parse_byte(b, e));
      @(negedge clock);
   endtask

   task automatic send_note();
      logic [7:0] b;
      send_item(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 6)) begin
         do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
         send_item(b, 1'b0);
      end
      send_item($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) send_note();
         else send_item(blank_pick(), 1'b0);
      end
   endtask

   task automatic send_number(input int unsigned value);
      string txt;
      txt = $sformatf("%0d", value);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_item(CH_ZERO, 1'b0);
      for (int i = 0; i < txt.len(); i++) begin
         send_item(txt[i], 1'b0);
         // a comment in the middle of a number must not split it
         if (i == 0 && txt.len() > 1 && $urandom_range(0, 7) == 0) send_note();
      end
   endtask

   // a byte that no header state accepts, or end of file
   task automatic send_bad();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_HASH || b == CH_P || digit_byte(b) || blank_byte(b));
      send_item(b, $urandom_range(0, 3) == 0);
   endtask

   task automatic test_magic();
      send_item(CH_P, 1'b0);
      if ($urandom_range(0, 1)) send_note();
      send_item(CH_SIX, 1'b0);
      if ($urandom_range(0, 2) == 0) send_note();
      send_item(blank_pick(), 1'b0);
   endtask

   task automatic test_header(input int unsigned w, input int unsigned h,
                              input int unsigned maxv);
      send_blanks();
      send_number(w);
      send_item(blank_pick(), 1'b0);
      send_blanks();
      send_number(h);
      send_item(blank_pick(), 1'b0);
      send_blanks();
      send_number(maxv);
      send_item(blank_pick(), 1'b0);
   endtask

   task automatic test_pixels(input int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) holds_requested++;
         if (i == n / 2) idle_on = 1'b0;
         if (i == n / 2 + 300) idle_on = 1'b1;
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_truncation();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // traffic after completion or an error leaves every output alone
   task automatic test_ignored(input int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) holds_requested++;
         if (i == n / 2) idle_on = 1'b0;
         if (i == n / 2 + 300) idle_on = 1'b1;
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_header_fault(input logic [3:0] kind);
      int unsigned v;
      case (kind)
         ERR_NO_P: send_bad();
         ERR_NO_6: begin
            send_item(CH_P, 1'b0);
            send_bad();
         end
         ERR_MAGIC_LEN: begin
            send_item(CH_P, 1'b0);
            send_item(CH_SIX, 1'b0);
            if ($urandom_range(0, 1)) send_item(CH_SIX, 1'b0); else send_bad();
         end
         ERR_EOF_CMT: begin
            send_item(CH_P, 1'b0);
            send_item(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5)) send_item(CH_P, 1'b0);
            test_truncation();
         end
         ERR_NO_DIGIT: begin
            test_magic();
            send_blanks();
            send_bad();
         end
         ERR_NON_DIGIT: begin
            test_magic();
            send_number($urandom_range(0, DIM_MAX));
            send_bad();
         end
         ERR_MAXVAL: begin
            v = $urandom_range(0, 1) ? $urandom_range(0, DIM_MAX) : $urandom_range(254, 256);
            if (v == MAXVAL_REQ) v = 0;
            test_magic();
            test_header($urandom_range(1, 9), $urandom_range(1, 9), v);
         end
         ERR_ZERO_SIZE: begin
            test_magic();
            case ($urandom_range(0, 2))
               0: test_header(0, $urandom_range(1, DIM_MAX), MAXVAL_REQ);
               1: test_header($urandom_range(1, DIM_MAX), 0, MAXVAL_REQ);
               default: test_header(0, 0, MAXVAL_REQ);
            endcase
         end
         default: begin
            // overflow: one digit past the largest size
            test_magic();
            send_blanks();
            if ($urandom_range(0, 1)) begin
               send_number(DIM_MAX / 10);
               send_item(CH_ZERO + 8'($urandom_range(6, 9)), 1'b0);
            end else begin
               send_number($urandom_range(DIM_MAX / 10 + 1, DIM_MAX));
               send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
         end
      endcase
   endtask

   // receiver: random idling plus an occasional long hold-off
   always @(negedge clock) begin : receiver
      int hold_left;
      int holds_done;
      if (holds_done != holds_requested) begin
         holds_done = holds_requested;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= !(idle_on && $urandom_range(0, 99) < 27);
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_phase, rsp_error_code, rsp_image_width, rsp_image_height,
                 rsp_pixel_valid, rsp_pixel_value, rsp_color_channel, rsp_last_pixel};
         if (predicted_rsp.size() == 0) begin
            if (mismatch_count < 10)
               $display("result transfer with nothing pending: %p", got);
            mismatch_count++;
         end else begin
            want = predicted_rsp.pop_front();
            if (got.phase !== want.phase || got.error_code !== want.error_code ||
                got.image_width !== want.image_width ||
                got.image_height !== want.image_height ||
                got.pixel_valid !== want.pixel_valid ||
                got.pixel_value !== want.pixel_value ||
                got.color_channel !== want.color_channel ||
                got.last_pixel !== want.last_pixel) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected %p, got %p", want, got);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int fate;
      int unsigned w;
      int unsigned h;
      logic [3:0] kind;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      fate = $urandom_range(0, 19);
      if (fate < 12) begin
         case ($urandom_range(0, 3))
            0: begin
               w = 1;
               h = $urandom_range(300, 466);
            end
            1: begin
               w = $urandom_range(300, 466);
               h = 1;
            end
            default: begin
               w = $urandom_range(2, 40);
               h = 1400 / (3 * w);
            end
         endcase
         test_magic();
         test_header(w, h, MAXVAL_REQ);
         test_pixels(3 * w * h);
         test_ignored(20);
      end else if (fate < 17) begin
         w = $urandom_range(0, 1) ? DIM_MAX : $urandom_range(1000, DIM_MAX);
         h = $urandom_range(1, DIM_MAX);
         test_magic();
         test_header(w, h, MAXVAL_REQ);
         test_pixels($urandom_range(1000, 1400));
         test_truncation();
         test_ignored(20);
      end else begin
         kind = 4'(ERR_NO_P + $urandom_range(0, 9));
         if (kind == ERR_TRUNC) kind = ERR_OVERFLOW;
         test_header_fault(kind);
         // a long ignored stream keeps the stall and back-to-back paths busy
         test_ignored(1400);
      end

      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
